// File: sv/alist_pkg.sv
// Package: shared types and codes for the array list engine.
package alist_pkg;

    localparam int unsigned VAL_W = 32;
    localparam int unsigned FUNC_W = 3;
    localparam int unsigned CNT_W = 7;
    localparam int unsigned STAT_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_BACK  = 3'd0,
        FN_POP_BACK   = 3'd1,
        FN_PUSH_FRONT = 3'd2,
        FN_POP_FRONT  = 3'd3,
        FN_DEL_MIN    = 3'd4
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD_AT,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN
    } t_cell_op;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic signed [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] min_value;
        logic [CNT_W-1:0]        count;
        logic [STAT_W-1:0]       status;
    } t_out;

endpackage

// File: sv/alist_cell.sv
// One list slot: holds an entry, shifts with its neighbors, relays the min-scan token.
module alist_cell
    import alist_pkg::*;
#(
    parameter int unsigned IDX_W = 6,
    parameter int unsigned FILL_W = 7,
    parameter int unsigned INDEX = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cell_op                i_op,
    input  logic [IDX_W-1:0]        i_idx,
    input  logic signed [VAL_W-1:0] i_data,
    input  logic signed [VAL_W-1:0] i_prev,
    input  logic signed [VAL_W-1:0] i_next,
    input  logic [FILL_W-1:0]       i_fill,
    input  logic                    i_tok_valid,
    input  logic signed [VAL_W-1:0] i_tok_best,
    input  logic [IDX_W-1:0]        i_tok_pos,
    input  logic signed [VAL_W-1:0] i_tok_last,
    output logic signed [VAL_W-1:0] o_val,
    output logic                    o_tok_valid,
    output logic signed [VAL_W-1:0] o_tok_best,
    output logic [IDX_W-1:0]        o_tok_pos,
    output logic signed [VAL_W-1:0] o_tok_last
);

    logic signed [VAL_W-1:0] r_val;
    logic                    r_tok_valid;
    logic signed [VAL_W-1:0] r_tok_best;
    logic [IDX_W-1:0]        r_tok_pos;
    logic signed [VAL_W-1:0] r_tok_last;
    logic                    w_in_range;
    logic                    w_take;
    logic                    w_is_last;

    assign w_in_range = FILL_W'(INDEX) < i_fill;
    assign w_take     = w_in_range && ((INDEX == 0) || (r_val < i_tok_best));
    assign w_is_last  = FILL_W'(INDEX) == (i_fill - FILL_W'(1));

    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_LOAD_AT: begin
                if (i_idx == IDX_W'(INDEX)) begin
                    r_val <= i_data;
                end
            end
            CELL_SHIFT_UP:   r_val <= i_prev;
            CELL_SHIFT_DOWN: r_val <= i_next;
            default:         r_val <= r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok_valid) begin
            r_tok_best <= w_take ? r_val : i_tok_best;
            r_tok_pos  <= w_take ? IDX_W'(INDEX) : i_tok_pos;
            r_tok_last <= w_is_last ? r_val : i_tok_last;
        end
    end

    assign o_val       = r_val;
    assign o_tok_valid = r_tok_valid;
    assign o_tok_best  = r_tok_best;
    assign o_tok_pos   = r_tok_pos;
    assign o_tok_last  = r_tok_last;

endmodule

// File: sv/array_list_engine.sv
// Top level: list controller, result buffering and the row of list cells.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+--------------------------------
//  in      | in  | i_in_valid / o_in_ready   | i_in_data  (func, value)
//  out     | out | o_out_valid / i_out_ready | o_out_data (min_value, count, status)
//
// Push, pop, unused and rejected requests: list updated at the transfer edge, result held in
//   the pending register r_res until it moves to r_out; next input transfer once r_res is empty.
// Delete-min: a token walks the cell row one cell a cycle; when it leaves the last cell the
//   last entry fills the vacated slot and the result enters r_res.
// Reset (synchronous, active low) empties the list; entry contents are not cleared.
// Output stall: a pending register takes one more result, then o_in_ready drops.
module array_list_engine
    import alist_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int unsigned FILL_W = $clog2(CAPACITY + 1);
    localparam int unsigned IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    t_state               r_state, n_state;
    logic [FILL_W-1:0]    r_fill, n_fill;
    logic                 r_res_valid;
    t_out                 r_res, n_res;
    logic                 w_res_set;
    logic                 r_out_valid;
    t_out                 r_out;
    logic                 w_acc;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_tok_start;
    t_cell_op             w_op;
    logic [IDX_W-1:0]     w_idx;
    logic signed [VAL_W-1:0] w_data;

    logic signed [VAL_W-1:0] w_val      [CAPACITY];
    logic                    w_tok_valid[CAPACITY];
    logic signed [VAL_W-1:0] w_tok_best [CAPACITY];
    logic [IDX_W-1:0]        w_tok_pos  [CAPACITY];
    logic signed [VAL_W-1:0] w_tok_last [CAPACITY];

    assign o_in_ready = (r_state == ST_IDLE) && !r_res_valid;
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_full     = r_fill == FILL_W'(CAPACITY);
    assign w_empty    = r_fill == '0;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_res       = r_res;
        w_res_set   = 1'b0;
        w_tok_start = 1'b0;
        w_op        = CELL_HOLD;
        w_idx       = IDX_W'(r_fill);
        w_data      = i_in_data.value;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    w_res_set        = 1'b1;
                    n_res.min_value  = '0;
                    n_res.status     = STAT_DONE;
                    unique case (t_func'(i_in_data.func))
                        FN_PUSH_BACK: begin
                            if (w_full) begin
                                n_res.status = STAT_FULL;
                            end else begin
                                w_op   = CELL_LOAD_AT;
                                n_fill = r_fill + FILL_W'(1);
                            end
                        end
                        FN_PUSH_FRONT: begin
                            if (w_full) begin
                                n_res.status = STAT_FULL;
                            end else begin
                                w_op   = CELL_SHIFT_UP;
                                n_fill = r_fill + FILL_W'(1);
                            end
                        end
                        FN_POP_BACK: begin
                            if (w_empty) begin
                                n_res.status = STAT_EMPTY;
                            end else begin
                                n_fill = r_fill - FILL_W'(1);
                            end
                        end
                        FN_POP_FRONT: begin
                            if (w_empty) begin
                                n_res.status = STAT_EMPTY;
                            end else begin
                                w_op   = CELL_SHIFT_DOWN;
                                n_fill = r_fill - FILL_W'(1);
                            end
                        end
                        FN_DEL_MIN: begin
                            if (w_empty) begin
                                n_res.status = STAT_EMPTY;
                            end else begin
                                w_res_set   = 1'b0;
                                w_tok_start = 1'b1;
                                n_state     = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_res.count = CNT_W'(n_fill);
                end
            end
            ST_SCAN: begin
                if (w_tok_valid[CAPACITY-1]) begin
                    // move last entry into the vacated slot
                    w_op            = CELL_LOAD_AT;
                    w_idx           = w_tok_pos[CAPACITY-1];
                    w_data          = w_tok_last[CAPACITY-1];
                    n_fill          = r_fill - FILL_W'(1);
                    w_res_set       = 1'b1;
                    n_res.min_value = w_tok_best[CAPACITY-1];
                    n_res.count     = CNT_W'(n_fill);
                    n_res.status    = STAT_DONE;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_res_valid && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
                r_res_valid <= 1'b0;
            end else begin
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
                if (w_res_set) begin
                    r_res_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_set) begin
            r_res <= n_res;
        end
        if (r_res_valid && (!r_out_valid || i_out_ready)) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VAL_W-1:0] w_prev;
        logic signed [VAL_W-1:0] w_next;
        logic                    w_tin_valid;
        logic signed [VAL_W-1:0] w_tin_best;
        logic [IDX_W-1:0]        w_tin_pos;
        logic signed [VAL_W-1:0] w_tin_last;

        if (g == 0) begin : g_head
            assign w_prev      = w_data;
            assign w_tin_valid = w_tok_start;
            assign w_tin_best  = '0;
            assign w_tin_pos   = '0;
            assign w_tin_last  = '0;
        end else begin : g_body
            assign w_prev      = w_val[g-1];
            assign w_tin_valid = w_tok_valid[g-1];
            assign w_tin_best  = w_tok_best[g-1];
            assign w_tin_pos   = w_tok_pos[g-1];
            assign w_tin_last  = w_tok_last[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next = w_val[g];
        end else begin : g_inner
            assign w_next = w_val[g+1];
        end

        alist_cell #(
            .IDX_W (IDX_W),
            .FILL_W(FILL_W),
            .INDEX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_op       (w_op),
            .i_idx      (w_idx),
            .i_data     (w_data),
            .i_prev     (w_prev),
            .i_next     (w_next),
            .i_fill     (r_fill),
            .i_tok_valid(w_tin_valid),
            .i_tok_best (w_tin_best),
            .i_tok_pos  (w_tin_pos),
            .i_tok_last (w_tin_last),
            .o_val      (w_val[g]),
            .o_tok_valid(w_tok_valid[g]),
            .o_tok_best (w_tok_best[g]),
            .o_tok_pos  (w_tok_pos[g]),
            .o_tok_last (w_tok_last[g])
        );
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(CAPACITY))
        else $error("fill above capacity");

    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok_valid[CAPACITY-1] |-> (r_state == ST_SCAN))
        else $error("scan token outside scan");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_in_data.func == FN_DEL_MIN) && !w_empty) |=> (r_state == ST_SCAN))
        else $error("delete-min did not start a scan");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == STAT_FULL))
            |-> (o_out_data.count == CNT_W'(CAPACITY)))
        else $error("full status with wrong count");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_out_valid && !i_out_ready) |=> (r_res_valid && $stable(r_res)))
        else $error("pending result lost");
`endif

endmodule

// File: tb/alist_checker.sv
// Checker for the array list engine: predicts each result and compares it with the output.
`timescale 1ns / 1ps

module alist_checker
    import alist_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_errors,
    output int   o_pending
);

    localparam int REPORT_LIMIT = 10;

    logic signed [VAL_W-1:0] list_copy [CAPACITY];
    int                      list_fill = 0;
    t_out                    expected_results [$];
    int                      mismatch_count = 0;

    function automatic t_out apply_list_op(input t_in req);
        t_out res;
        int   pos;
        res        = '0;
        res.status = STAT_DONE;
        case (req.func)
            FN_PUSH_BACK: begin
                if (list_fill >= CAPACITY) begin
                    res.status = STAT_FULL;
                end else begin
                    list_copy[list_fill] = req.value;
                    list_fill++;
                end
            end
            FN_POP_BACK: begin
                if (list_fill == 0) res.status = STAT_EMPTY;
                else list_fill--;
            end
            FN_PUSH_FRONT: begin
                if (list_fill >= CAPACITY) begin
                    res.status = STAT_FULL;
                end else begin
                    for (int i = list_fill; i > 0; i--) list_copy[i] = list_copy[i-1];
                    list_copy[0] = req.value;
                    list_fill++;
                end
            end
            FN_POP_FRONT: begin
                if (list_fill == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    for (int i = 1; i < list_fill; i++) list_copy[i-1] = list_copy[i];
                    list_fill--;
                end
            end
            FN_DEL_MIN: begin
                if (list_fill == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    // strict compare keeps the first of equal minima
                    pos = 0;
                    for (int i = 1; i < list_fill; i++) begin
                        if (list_copy[i] < list_copy[pos]) pos = i;
                    end
                    res.min_value  = list_copy[pos];
                    list_copy[pos] = list_copy[list_fill-1];
                    list_fill--;
                end
            end
            default: ;
        endcase
        res.count = CNT_W'(list_fill);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            list_fill = 0;
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(apply_list_op(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result: min %0d count %0d status %0d",
                                 $realtime, i_out_data.min_value, i_out_data.count,
                                 i_out_data.status);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.min_value !== want.min_value ||
                        i_out_data.count !== want.count ||
                        i_out_data.status !== want.status) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("%0t: want %0d/%0d/%0d got %0d/%0d/%0d (min/count/status)",
                                     $realtime, want.min_value, want.count, want.status,
                                     i_out_data.min_value, i_out_data.count,
                                     i_out_data.status);
                        end
                    end
                end
            end
        end
        o_errors  <= mismatch_count;
        o_pending <= expected_results.size();
    end

endmodule

// File: tb/testbench.sv
// Testbench top: clock, reset, request stimulus, result back-pressure and the verdict.
`timescale 1ns / 1ps

module testbench;
    import alist_pkg::*;

    localparam int unsigned LIST_CAP    = 64;
    localparam int          CLK_PERIOD  = 8;
    localparam int          RANDOM_REQS = 1830;
    localparam int          QUIET_REQS  = 200;
    localparam int          LONG_HOLD   = 300;
    localparam int          STALL_LIMIT = 4000;

    localparam logic [FUNC_W-1:0]       FN_UNUSED_LO = 3'd5;
    localparam logic [FUNC_W-1:0]       FN_UNUSED_MID = 3'd6;
    localparam logic [FUNC_W-1:0]       FN_UNUSED_HI = 3'd7;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} t_mix;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_data;
    logic out_valid;
    logic out_ready;
    t_out out_data;
    int   errors;
    int   pending;
    int   idle_cycles = 0;
    int   hold_requests = 0;
    logic quiet = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    array_list_engine #(
        .CAPACITY(LIST_CAP)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    alist_checker #(
        .CAPACITY(LIST_CAP)
    ) u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_in_data  (in_data),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_out_data (out_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    function automatic t_in make_request(input logic [FUNC_W-1:0] f,
                                         input logic signed [VAL_W-1:0] v);
        t_in r;
        r.func  = f;
        r.value = v;
        return r;
    endfunction

    task automatic send_request(input t_in req);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
    endtask

    // result side back-pressure
    initial begin
        int holds_served;
        holds_served = 0;
        out_ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            if (hold_requests > holds_served) begin
                holds_served++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_mix                    mix;
        int                      burst_left;
        int                      r;
        logic [FUNC_W-1:0]       f;
        logic signed [VAL_W-1:0] v;

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, unused codes, extremes, equal minima
        send_request(make_request(FN_POP_BACK, 0));
        send_request(make_request(FN_POP_FRONT, 0));
        send_request(make_request(FN_DEL_MIN, 0));
        send_request(make_request(FN_UNUSED_LO, VAL_MAX));
        send_request(make_request(FN_PUSH_BACK, VAL_MAX));
        send_request(make_request(FN_PUSH_FRONT, VAL_MIN));
        send_request(make_request(FN_PUSH_BACK, 0));
        send_request(make_request(FN_PUSH_FRONT, -1));
        send_request(make_request(FN_UNUSED_MID, VAL_MIN));
        send_request(make_request(FN_DEL_MIN, 0));
        send_request(make_request(FN_PUSH_BACK, -5));
        send_request(make_request(FN_PUSH_FRONT, 3));
        send_request(make_request(FN_PUSH_BACK, -5));
        send_request(make_request(FN_PUSH_BACK, 9));
        send_request(make_request(FN_DEL_MIN, 0));
        send_request(make_request(FN_DEL_MIN, 0));
        send_request(make_request(FN_POP_FRONT, 0));
        send_request(make_request(FN_POP_BACK, 0));
        send_request(make_request(FN_UNUSED_HI, -1));
        send_request(make_request(FN_PUSH_FRONT, 1));
        send_request(make_request(FN_DEL_MIN, 0));
        send_request(make_request(FN_DEL_MIN, 0));
        send_request(make_request(FN_POP_FRONT, 0));
        send_request(make_request(FN_POP_BACK, 0));
        send_request(make_request(FN_DEL_MIN, 0));

        mix        = MIX_GROW;
        burst_left = 0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == 500 || n == 1300) hold_requests++;
            if (n >= RANDOM_REQS - QUIET_REQS || (n >= 900 && n < 980)) quiet = 1'b1;
            else quiet = 1'b0;
            if (burst_left == 0) begin
                burst_left = $urandom_range(40, 110);
                case ($urandom_range(0, 2))
                    0:       mix = MIX_GROW;
                    1:       mix = MIX_SHRINK;
                    default: mix = MIX_EVEN;
                endcase
            end
            burst_left--;

            r = $urandom_range(0, 99);
            if (r < 3) begin
                f = FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
            end else begin
                case (mix)
                    MIX_GROW:
                        f = (r < 60) ? FN_PUSH_BACK : (r < 85) ? FN_PUSH_FRONT :
                            (r < 91) ? FN_POP_BACK : (r < 95) ? FN_POP_FRONT : FN_DEL_MIN;
                    MIX_SHRINK:
                        f = (r < 8) ? FN_PUSH_BACK : (r < 13) ? FN_PUSH_FRONT :
                            (r < 38) ? FN_POP_BACK : (r < 63) ? FN_POP_FRONT : FN_DEL_MIN;
                    default:
                        f = (r < 28) ? FN_PUSH_BACK : (r < 45) ? FN_PUSH_FRONT :
                            (r < 62) ? FN_POP_BACK : (r < 78) ? FN_POP_FRONT : FN_DEL_MIN;
                endcase
            end

            case ($urandom_range(0, 9))
                0:       v = VAL_MAX;
                1:       v = VAL_MIN;
                2, 3, 4: v = $urandom_range(0, 8) - 4;
                default: v = $urandom();
            endcase

            send_request(make_request(f, v));
        end
        in_valid <= 1'b0;

        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LIST_CAP + 16) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
